/* src/alm_pkg.sv */
// ----------------------------------------------------------------------------
// Audio level meter package
// Shared widths, payload structs, controller commands and state codes.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int SLOT_BITS   = 32;
  localparam int SAMPLE_BITS = 24;
  localparam int SLOT_SHIFT  = SLOT_BITS - SAMPLE_BITS;
  localparam int SUM_BITS    = COUNT_BITS + SAMPLE_BITS;
  localparam int SQ_BITS     = 64;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int DIV_STEPS   = SQ_BITS;
  localparam int SQRT_STEPS  = SQ_BITS / 2;
  localparam int ITER_BITS   = $clog2(DIV_STEPS);

  localparam logic [SAMPLE_BITS-1:0] CLIP_LEVEL = SAMPLE_BITS'(24'h7FFFFF);
  localparam logic                   REQ_FINISH = 1'b1;
  localparam logic                   SEL_RIGHT  = 1'b1;

  typedef struct packed {
    logic                        req_type;
    logic signed [SLOT_BITS-1:0] left_slot;
    logic signed [SLOT_BITS-1:0] right_slot;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]         window_samples;
    logic [COUNT_BITS-1:0]         nonzero_count;
    logic [COUNT_BITS-1:0]         clipped_count;
    logic [SAMPLE_BITS-1:0]        peak_level;
    logic signed [SAMPLE_BITS-1:0] mean_level;
    logic [SAMPLE_BITS-1:0]        rms_level;
    logic                          overflow;
  } out_item_t;

  typedef struct packed {
    logic load_mean;
    logic div_step;
    logic load_square;
    logic load_root;
    logic root_step;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic root_last;
    logic out_full;
  } ctrl_status_t;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_LOAD_M = 8'b0000_0010,
    ST_DIV_M  = 8'b0000_0100,
    ST_LOAD_S = 8'b0000_1000,
    ST_DIV_S  = 8'b0001_0000,
    ST_LOAD_R = 8'b0010_0000,
    ST_ROOT   = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

endpackage

/* src/alm_ctrl.sv */
// ----------------------------------------------------------------------------
// Audio level meter controller
// Sequences the finish work: mean divide, mean-square divide, square root.
// ----------------------------------------------------------------------------
module alm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  finish,
  input  alm_pkg::ctrl_status_t status,
  output alm_pkg::ctrl_cmd_t    cmd,
  output logic                  idle
);

  alm_pkg::state_t state;
  alm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      alm_pkg::ST_IDLE: begin
        if (finish) begin
          state_next = alm_pkg::ST_LOAD_M;
        end
      end
      alm_pkg::ST_LOAD_M: begin
        cmd.load_mean = 1'b1;
        state_next    = alm_pkg::ST_DIV_M;
      end
      alm_pkg::ST_DIV_M: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = alm_pkg::ST_LOAD_S;
        end
      end
      alm_pkg::ST_LOAD_S: begin
        cmd.load_square = 1'b1;
        state_next      = alm_pkg::ST_DIV_S;
      end
      alm_pkg::ST_DIV_S: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = alm_pkg::ST_LOAD_R;
        end
      end
      alm_pkg::ST_LOAD_R: begin
        cmd.load_root = 1'b1;
        state_next    = alm_pkg::ST_ROOT;
      end
      alm_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = alm_pkg::ST_DONE;
        end
      end
      alm_pkg::ST_DONE: begin
        if (!status.out_full) begin
          cmd.publish = 1'b1;
          state_next  = alm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = alm_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle = (state == alm_pkg::ST_IDLE);

endmodule

/* src/alm_dp.sv */
// ----------------------------------------------------------------------------
// Audio level meter datapath
// Sample pipeline, window accumulators, shared divider, square root and
// result register.
// ----------------------------------------------------------------------------
module alm_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  frame_accept,
  input  alm_pkg::in_item_t     in_data,
  input  alm_pkg::ctrl_cmd_t    cmd,
  output alm_pkg::ctrl_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output alm_pkg::out_item_t    out_data
);

  localparam int CB = alm_pkg::COUNT_BITS;
  localparam int SB = alm_pkg::SAMPLE_BITS;
  localparam int QB = alm_pkg::SQ_BITS;
  localparam logic [QB-1:0] ROOT_START = QB'(1) << (QB - 2);

  logic channel_select;

  logic signed [alm_pkg::SLOT_BITS-1:0] sel_slot;
  logic [SB-1:0]                        in_sample;
  logic [SB-1:0]                        in_mag;

  logic                           st_valid;
  logic signed [SB-1:0]           st_sample;
  logic [SB-1:0]                  st_mag;
  logic [alm_pkg::PROD_BITS-1:0]  st_square;

  logic [CB-1:0]                      count_acc;
  logic [CB-1:0]                      nonzero_acc;
  logic [CB-1:0]                      clip_acc;
  logic [SB-1:0]                      peak_reg;
  logic signed [alm_pkg::SUM_BITS-1:0] sum_acc;
  logic [QB-1:0]                      square_acc;
  logic                               overflow_flag;

  logic                                count_full;
  logic [QB:0]                         square_sum;
  logic signed [alm_pkg::SUM_BITS-1:0] sample_ext;
  logic [alm_pkg::SUM_BITS-1:0]        sum_mag;

  logic [CB-1:0]                 rem;
  logic [QB-1:0]                 quo;
  logic [QB-1:0]                 root;
  logic [QB-1:0]                 bitv;
  logic [alm_pkg::ITER_BITS-1:0] iter;
  logic                          mean_neg;
  logic [SB-1:0]                 mean_val;
  logic [SB-1:0]                 mean_q;

  logic [CB:0]   rem_shift;
  logic [CB:0]   rem_diff;
  logic          rem_ge;
  logic [QB-1:0] root_try;
  logic          count_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= 1'b0;
    end else if (cfg_wr_en) begin
      channel_select <= cfg_wr_data;
    end
  end

  assign sel_slot  = (channel_select == alm_pkg::SEL_RIGHT) ? in_data.right_slot
                                                            : in_data.left_slot;
  assign in_sample = sel_slot[alm_pkg::SLOT_BITS-1:alm_pkg::SLOT_SHIFT];
  assign in_mag    = in_sample[SB-1] ? (~in_sample + 1'b1) : in_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else begin
      st_valid <= frame_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_accept) begin
      st_sample <= in_sample;
      st_mag    <= in_mag;
      st_square <= alm_pkg::PROD_BITS'(in_mag) * alm_pkg::PROD_BITS'(in_mag);
    end
  end

  assign count_full = (count_acc == {CB{1'b1}});
  assign square_sum = {1'b0, square_acc} + (QB + 1)'(st_square);
  assign sample_ext = alm_pkg::SUM_BITS'(st_sample);

  always_ff @(posedge clk) begin
    if (rst || cmd.publish) begin
      count_acc     <= '0;
      nonzero_acc   <= '0;
      clip_acc      <= '0;
      peak_reg      <= '0;
      sum_acc       <= '0;
      square_acc    <= '0;
      overflow_flag <= 1'b0;
    end else if (st_valid) begin
      if (count_full) begin
        overflow_flag <= 1'b1;
      end else begin
        count_acc <= count_acc + 1'b1;
        if (st_sample != '0) begin
          nonzero_acc <= nonzero_acc + 1'b1;
        end
        if (st_mag >= alm_pkg::CLIP_LEVEL) begin
          clip_acc <= clip_acc + 1'b1;
        end
        if (st_mag > peak_reg) begin
          peak_reg <= st_mag;
        end
        sum_acc <= sum_acc + sample_ext;
        if (square_sum[QB]) begin
          square_acc    <= {QB{1'b1}};
          overflow_flag <= 1'b1;
        end else begin
          square_acc <= square_sum[QB-1:0];
        end
      end
    end
  end

  assign sum_mag   = sum_acc[alm_pkg::SUM_BITS-1] ? (~sum_acc + 1'b1) : sum_acc;
  assign rem_shift = {rem, quo[QB-1]};
  assign rem_diff  = rem_shift - {1'b0, count_acc};
  assign rem_ge    = (rem_shift >= {1'b0, count_acc});
  assign root_try  = root + bitv;
  assign mean_q    = quo[SB-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_mean) begin
      rem      <= '0;
      quo      <= QB'(sum_mag);
      mean_neg <= sum_acc[alm_pkg::SUM_BITS-1];
      iter     <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= rem_diff[CB-1:0];
        quo <= {quo[QB-2:0], 1'b1};
      end else begin
        rem <= rem_shift[CB-1:0];
        quo <= {quo[QB-2:0], 1'b0};
      end
      iter <= iter + 1'b1;
    end else if (cmd.load_square) begin
      mean_val <= mean_neg ? (~mean_q + 1'b1) : mean_q;
      rem      <= '0;
      quo      <= square_acc;
      iter     <= '0;
    end else if (cmd.load_root) begin
      root <= '0;
      bitv <= ROOT_START;
      iter <= '0;
    end else if (cmd.root_step) begin
      if (quo >= root_try) begin
        quo  <= quo - root_try;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
      iter <= iter + 1'b1;
    end
  end

  assign count_zero = (count_acc == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data.window_samples <= count_acc;
      out_data.nonzero_count  <= nonzero_acc;
      out_data.clipped_count  <= clip_acc;
      out_data.peak_level     <= peak_reg;
      out_data.mean_level     <= count_zero ? '0 : mean_val;
      out_data.rms_level      <= count_zero ? '0 : root[SB-1:0];
      out_data.overflow       <= overflow_flag;
    end
  end

  assign status.div_last  = (iter == alm_pkg::ITER_BITS'(alm_pkg::DIV_STEPS - 1));
  assign status.root_last = (iter == alm_pkg::ITER_BITS'(alm_pkg::SQRT_STEPS - 1));
  assign status.out_full  = out_valid && out_stall;

`ifndef SYNTHESIS
  a_clear_after_publish: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> (count_acc == '0) && (square_acc == '0) && !overflow_flag)
    else $error("window not cleared after result");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (nonzero_acc <= count_acc) && (clip_acc <= count_acc))
    else $error("sub-count exceeds sample count");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !cmd.publish |=> count_acc >= $past(count_acc))
    else $error("sample count decreased without clear");

  a_stage_from_accept: assert property (@(posedge clk) disable iff (rst)
    st_valid |-> $past(frame_accept))
    else $error("sample stage loaded without frame transfer");

  a_publish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
`endif

endmodule

/* src/audio_level_meter.sv */
// ----------------------------------------------------------------------------
// Audio level meter
// Window statistics (counts, peak, mean, rms) of one channel of stereo frames.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries frames (req_type 0) and
// finish requests (req_type 1). The config write port cfg_wr_en/cfg_wr_data
// sets channel_select (0 left slot, 1 right slot); write it only while idle.
// A frame transfers while the meter is idle, and a new frame may follow every
// idle cycle; its sample is staged, then enters the window accumulators.
// A finish request produces one result on out_valid/out_stall/out_data. It
// runs a 64-step restoring divide for the mean, a second 64-step divide for
// the mean square and a 32-step square root, all on one shared iteration
// counter. in_stall is high from the finish transfer until the result is
// published, and the window is then cleared.
// The result register holds a finished result while out_stall is high; the
// next frames are taken meanwhile, and a following finish waits in its last
// step until the register is free.
// Reset clears the window, the result valid and channel_select.
// ----------------------------------------------------------------------------
module audio_level_meter (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  alm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output alm_pkg::out_item_t out_data
);

  alm_pkg::ctrl_cmd_t    cmd;
  alm_pkg::ctrl_status_t status;
  logic                  idle;
  logic                  in_xfer;
  logic                  finish;
  logic                  frame_accept;

  assign in_stall     = !idle;
  assign in_xfer      = in_valid && !in_stall;
  assign finish       = in_xfer && (in_data.req_type == alm_pkg::REQ_FINISH);
  assign frame_accept = in_xfer && (in_data.req_type != alm_pkg::REQ_FINISH);

  alm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .finish (finish),
    .status (status),
    .cmd    (cmd),
    .idle   (idle)
  );

  alm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .frame_accept (frame_accept),
    .in_data      (in_data),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule

/* sim/audio_level_meter_test.sv */
// ----------------------------------------------------------------------------
// Audio level meter testbench
// Sends stereo frames and finish requests to the meter and checks every
// window report against a local model of the window statistics. A directed
// table covers the empty window, full-scale samples, channel select and
// back-to-back finishes. Random phases follow, with select changes. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module audio_level_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_FRAME    = ~alm_pkg::REQ_FINISH;
  localparam int   DRAIN_CYCLES = 200;
  localparam int   RANDOM_ITEMS = 1650;
  localparam int   CYCLE_LIMIT  = 5_000_000;
  localparam int   N_DIRECTED   = 22;

  typedef enum logic [1:0] {
    ROW_FRAME,
    ROW_FINISH,
    ROW_SELECT
  } row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               sel;
    logic [31:0]        left;
    logic [31:0]        right;
    logic               typed;
    alm_pkg::out_item_t report;
  } dir_row_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  alm_pkg::in_item_t  in_data     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  alm_pkg::out_item_t out_data;

  int                 cycle_count    = 0;
  int                 mismatch_count = 0;
  int                 items_sent     = 0;
  bit                 no_idle        = 1'b0;
  alm_pkg::out_item_t expected_reports [$];

  logic                                chan_sel;
  logic [alm_pkg::COUNT_BITS-1:0]      win_count;
  logic [alm_pkg::COUNT_BITS-1:0]      win_nonzero;
  logic [alm_pkg::COUNT_BITS-1:0]      win_clipped;
  logic [alm_pkg::SAMPLE_BITS-1:0]     win_peak;
  logic signed [alm_pkg::SUM_BITS-1:0] win_sum;
  logic [alm_pkg::SQ_BITS-1:0]         win_sq;
  logic                                win_ovf;

  dir_row_t directed [N_DIRECTED] = '{
    '{ROW_FINISH, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1, '0},
    '{ROW_FRAME,  1'b0, 32'h8000_0000, 32'h7FFF_FF00, 1'b0, '0},
    '{ROW_FINISH, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1,
      alm_pkg::out_item_t'{20'd1, 20'd1, 20'd1, 24'h800000, 24'h800000, 24'h800000,
                           1'b0}},
    '{ROW_SELECT, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_FRAME,  1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_FINISH, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1,
      alm_pkg::out_item_t'{20'd1, 20'd1, 20'd1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                           1'b0}},
    '{ROW_FRAME,  1'b0, 32'h1234_5678, 32'h0000_00FF, 1'b0, '0},
    '{ROW_FRAME,  1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{ROW_FINISH, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1,
      alm_pkg::out_item_t'{20'd2, 20'd0, 20'd0, 24'h0, 24'h0, 24'h0, 1'b0}},
    '{ROW_FRAME,  1'b0, 32'h7FFF_FF00, 32'hFFFF_FE00, 1'b0, '0},
    '{ROW_FRAME,  1'b0, 32'h0000_0000, 32'hFFFF_FF00, 1'b0, '0},
    '{ROW_FINISH, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1,
      alm_pkg::out_item_t'{20'd2, 20'd2, 20'd0, 24'h2, 24'hFFFFFF, 24'h1, 1'b0}},
    '{ROW_FRAME,  1'b0, 32'h0000_0000, 32'h8000_0100, 1'b0, '0},
    '{ROW_FRAME,  1'b0, 32'h0000_0000, 32'h7FFF_FE00, 1'b0, '0},
    '{ROW_FRAME,  1'b0, 32'h0000_0000, 32'h0000_01FF, 1'b0, '0},
    '{ROW_FRAME,  1'b0, 32'h0000_0000, 32'h8000_00AA, 1'b0, '0},
    '{ROW_FINISH, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0},
    '{ROW_FINISH, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '0},
    '{ROW_SELECT, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
    '{ROW_FRAME,  1'b0, 32'hEDCB_A987, 32'h0000_0000, 1'b0, '0},
    '{ROW_FRAME,  1'b0, 32'h0000_0100, 32'h8000_0000, 1'b0, '0},
    '{ROW_FINISH, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0}
  };

  audio_level_meter dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[audio_level_meter] ERROR");
      $finish;
    end
  end

  function automatic logic [alm_pkg::SQ_BITS-1:0] floor_sqrt(
    input logic [alm_pkg::SQ_BITS-1:0] x
  );
    logic [alm_pkg::SQ_BITS-1:0] root;
    logic [alm_pkg::SQ_BITS-1:0] trial;
    root = '0;
    for (int b = alm_pkg::SQRT_STEPS - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic logic [alm_pkg::SLOT_BITS-1:0] draw_slot();
    logic [alm_pkg::SLOT_BITS-1:0] low;
    low = alm_pkg::SLOT_BITS'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 | low;
      1: return 32'h7FFF_FF00 | low;
      2: return 32'h8000_0100 | low;
      3: return 32'h7FFF_FE00 | low;
      4: return ((alm_pkg::SLOT_BITS'($urandom_range(0, 1023)) - 32'd512)
                 << alm_pkg::SLOT_SHIFT) | low;
      default: return $urandom();
    endcase
  endfunction

  task automatic clear_window();
    win_count   = '0;
    win_nonzero = '0;
    win_clipped = '0;
    win_peak    = '0;
    win_sum     = '0;
    win_sq      = '0;
    win_ovf     = 1'b0;
  endtask

  task automatic window_predict(input alm_pkg::in_item_t item);
    logic signed [alm_pkg::SLOT_BITS-1:0]   slot;
    logic signed [alm_pkg::SAMPLE_BITS-1:0] sample;
    logic [alm_pkg::SAMPLE_BITS-1:0]        mag;
    logic [alm_pkg::SQ_BITS-1:0]            sq;
    logic signed [alm_pkg::SUM_BITS-1:0]    quot;
    alm_pkg::out_item_t                     rep;
    if (item.req_type == alm_pkg::REQ_FINISH) begin
      rep = '0;
      if (win_count != '0) begin
        quot = win_sum / $signed({{(alm_pkg::SUM_BITS - alm_pkg::COUNT_BITS){1'b0}},
                                  win_count});
        rep.mean_level = quot[alm_pkg::SAMPLE_BITS-1:0];
        rep.rms_level  = alm_pkg::SAMPLE_BITS'(
                           floor_sqrt(win_sq / alm_pkg::SQ_BITS'(win_count)));
      end
      rep.window_samples = win_count;
      rep.nonzero_count  = win_nonzero;
      rep.clipped_count  = win_clipped;
      rep.peak_level     = win_peak;
      rep.overflow       = win_ovf;
      expected_reports.push_back(rep);
      clear_window();
    end else begin
      slot   = (chan_sel == alm_pkg::SEL_RIGHT) ? item.right_slot : item.left_slot;
      sample = slot[alm_pkg::SLOT_BITS-1:alm_pkg::SLOT_SHIFT];
      mag    = sample[alm_pkg::SAMPLE_BITS-1] ? -sample : sample;
      sq     = alm_pkg::SQ_BITS'(mag) * alm_pkg::SQ_BITS'(mag);
      if (win_count == '1) begin
        win_ovf = 1'b1;
      end else begin
        win_count++;
        if (sample != '0) win_nonzero++;
        if (mag >= alm_pkg::CLIP_LEVEL) win_clipped++;
        if (mag > win_peak) win_peak = mag;
        win_sum = win_sum + sample;
        if (win_sq > ~sq) begin
          win_sq  = '1;
          win_ovf = 1'b1;
        end else begin
          win_sq = win_sq + sq;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(input alm_pkg::in_item_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    window_predict(item);
    items_sent++;
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_select(input logic sel);
    drain_reports();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sel;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chan_sel = sel;
  endtask

  // result side: stall a drawn number of cycles of valid output, then take one transfer
  initial begin
    int                 hold;
    int                 seen;
    alm_pkg::out_item_t got;
    alm_pkg::out_item_t want;
    while (rst) @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 7);
      if (hold != 0) out_stall <= 1'b1;
      seen = 0;
      while (seen < hold) begin
        @(posedge clk);
        if (out_valid) seen++;
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = out_data;
      if (expected_reports.size() == 0) begin
        report_mismatch("result with none expected", got.window_samples, 0);
      end else begin
        want = expected_reports.pop_front();
        if (got.window_samples !== want.window_samples)
          report_mismatch("window_samples", got.window_samples, want.window_samples);
        if (got.nonzero_count !== want.nonzero_count)
          report_mismatch("nonzero_count", got.nonzero_count, want.nonzero_count);
        if (got.clipped_count !== want.clipped_count)
          report_mismatch("clipped_count", got.clipped_count, want.clipped_count);
        if (got.peak_level !== want.peak_level)
          report_mismatch("peak_level", got.peak_level, want.peak_level);
        if (got.mean_level !== want.mean_level)
          report_mismatch("mean_level", got.mean_level, want.mean_level);
        if (got.rms_level !== want.rms_level)
          report_mismatch("rms_level", got.rms_level, want.rms_level);
        if (got.overflow !== want.overflow)
          report_mismatch("overflow", got.overflow, want.overflow);
      end
    end
  end

  initial begin
    dir_row_t          row;
    alm_pkg::in_item_t item;
    int                random_end;
    chan_sel = 1'b0;
    clear_window();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      row = directed[i];
      if (row.kind == ROW_SELECT) begin
        write_select(row.sel);
      end else begin
        item.req_type   = (row.kind == ROW_FINISH) ? alm_pkg::REQ_FINISH : REQ_FRAME;
        item.left_slot  = row.left;
        item.right_slot = row.right;
        send_item(item);
        if (row.typed) expected_reports[expected_reports.size() - 1] = row.report;
      end
    end

    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      no_idle = ($urandom_range(0, 3) == 0);
      write_select(1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 19))
          0:       row.sel = 1'b0;
          default: row.sel = 1'b1;
        endcase
        item.req_type = REQ_FRAME;
        if (row.sel) begin
          repeat (($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24)) begin
            item.left_slot  = draw_slot();
            item.right_slot = draw_slot();
            send_item(item);
          end
        end
        item.req_type   = alm_pkg::REQ_FINISH;
        item.left_slot  = $urandom();
        item.right_slot = $urandom();
        send_item(item);
      end
      // leave a few frames open across the next select change
      item.req_type = REQ_FRAME;
      repeat ($urandom_range(0, 3)) begin
        item.left_slot  = draw_slot();
        item.right_slot = draw_slot();
        send_item(item);
      end
    end
    no_idle = 1'b0;
    item.req_type = alm_pkg::REQ_FINISH;
    send_item(item);

    drain_reports();
    if (mismatch_count == 0) begin
      $display("[audio_level_meter] OK");
    end else begin
      $display("[audio_level_meter] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/alm_pkg.sv
src/alm_ctrl.sv
src/alm_dp.sv
src/audio_level_meter.sv
sim/audio_level_meter_test.sv
